/* rtl/ppdmd_pkg.sv */
// ----------------------------------------------------------------------------
// Per-pixel depth statistics package
// Widths, codes, stage records and constants shared by the depth statistics
// block and its channel interfaces.
// ----------------------------------------------------------------------------
package ppdmd_pkg;

    localparam int PIXELS     = 4096;
    localparam int MAX_FRAMES = 1024;
    localparam int ADDR_W     = $clog2(PIXELS);

    localparam int PIX_W  = 12;
    localparam int RAW_W  = 16;
    localparam int CNT_W  = 11;
    localparam int SUM_W  = 26;
    localparam int MEAN_W = 24;
    localparam int SQ_W   = 58;
    localparam int FRAC_W = 8;
    localparam int PROD_W = 2 * MEAN_W;
    localparam int ACC_W  = CNT_W + SUM_W;

    localparam int DIV_N  = SQ_W;
    localparam int SQRT_N = SQ_W / 2;
    localparam int ROOT_W = SQRT_N;
    localparam int SREM_W = ROOT_W + 2;
    localparam int PEND_W = $clog2(DIV_N + 8);

    localparam int CFG_IDX_W = 1;
    localparam int CFG_W     = 16;

    localparam logic [CFG_IDX_W-1:0] CFG_MIN_RAW = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_MAX_RAW = 1'b1;

    localparam logic [RAW_W-1:0] MIN_RAW_RESET = 16'd3200;
    localparam logic [RAW_W-1:0] MAX_RAW_RESET = 16'd64000;

    typedef enum logic [1:0] {
        ACT_SUM  = 2'd0,
        ACT_MEAN = 2'd1,
        ACT_DEV  = 2'd2,
        ACT_READ = 2'd3
    } t_action;

    typedef struct packed {
        logic             valid;
        t_action          act;
        logic [PIX_W-1:0] px;
        logic             ok;
        logic             sv;
    } t_ctl;

    typedef struct packed {
        t_ctl             ctl;
        logic [RAW_W-1:0] raw;
    } t_s1;

    typedef struct packed {
        t_ctl              ctl;
        logic              acc_we;
        logic [ACC_W-1:0]  acc_wdata;
        logic [SQ_W-1:0]   sq_old;
        logic [PROD_W-1:0] term;
        logic [SQ_W-1:0]   dividend;
        logic [CNT_W-1:0]  divisor;
        logic              zero;
        logic [CNT_W-1:0]  cnt;
        logic [MEAN_W-1:0] mean;
    } t_upd;

    typedef struct packed {
        t_ctl              ctl;
        logic [CNT_W-1:0]  cnt;
        logic [MEAN_W-1:0] mean;
        logic              zero;
        logic [CNT_W-1:0]  divisor;
        logic [CNT_W-1:0]  rem;
        logic [SQ_W-1:0]   work;
    } t_div;

    typedef struct packed {
        t_ctl              ctl;
        logic [CNT_W-1:0]  cnt;
        logic [MEAN_W-1:0] mean;
        logic              zero;
        logic [SREM_W-1:0] rem;
        logic [ROOT_W-1:0] root;
        logic [SQ_W-1:0]   val;
    } t_sqr;

endpackage

/* rtl/ppdmd_in_if.sv */
// ----------------------------------------------------------------------------
// Depth sample channel
// Valid/ready channel that carries one action beat for one pixel.
// ----------------------------------------------------------------------------
interface ppdmd_in_if;
    logic                         valid;
    logic                         ready;
    logic [1:0]                   action;
    logic [ppdmd_pkg::PIX_W-1:0]  pixel_index;
    logic [ppdmd_pkg::RAW_W-1:0]  raw_depth;

    modport source (output valid, output action, output pixel_index, output raw_depth,
                    input ready);
    modport sink   (input valid, input action, input pixel_index, input raw_depth,
                    output ready);
endinterface

/* rtl/ppdmd_out_if.sv */
// ----------------------------------------------------------------------------
// Pixel statistics channel
// Valid/ready channel that carries one readout beat for one pixel.
// ----------------------------------------------------------------------------
interface ppdmd_out_if;
    logic                          valid;
    logic                          ready;
    logic [ppdmd_pkg::PIX_W-1:0]   result_pixel;
    logic [ppdmd_pkg::CNT_W-1:0]   sample_count;
    logic [ppdmd_pkg::MEAN_W-1:0]  mean_depth;
    logic [ppdmd_pkg::MEAN_W-1:0]  std_deviation;

    modport source (output valid, output result_pixel, output sample_count,
                    output mean_depth, output std_deviation, input ready);
    modport sink   (input valid, input result_pixel, input sample_count,
                    input mean_depth, input std_deviation, output ready);
endinterface

/* rtl/per_pixel_depth_mean_and_deviation.sv */
// ----------------------------------------------------------------------------
// Per-pixel depth mean and deviation
// A readout beat passes 91 register stages after it is accepted (3 update
// stages, 58 divider stages, 29 square root stages, output register).
// One beat per cycle is taken unless a held readout stalls the pipeline; a
// beat waits while an update to its pixel is still in the three update
// stages; a deviation or readout beat waits while a mean is in those stages or
// the divider. A clearing pass after reset zeroes all stores before any beat.
// ----------------------------------------------------------------------------
module per_pixel_depth_mean_and_deviation (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_cfg_we,
    input  logic [ppdmd_pkg::CFG_IDX_W-1:0]     i_cfg_index,
    input  logic [ppdmd_pkg::CFG_W-1:0]         i_cfg_data,
    ppdmd_in_if.sink                            i_in,
    ppdmd_out_if.source                         o_out
);

    localparam int ADDR_W = ppdmd_pkg::ADDR_W;
    localparam int CNT_W  = ppdmd_pkg::CNT_W;
    localparam int SUM_W  = ppdmd_pkg::SUM_W;
    localparam int MEAN_W = ppdmd_pkg::MEAN_W;
    localparam int SQ_W   = ppdmd_pkg::SQ_W;
    localparam int ACC_W  = ppdmd_pkg::ACC_W;
    localparam int PROD_W = ppdmd_pkg::PROD_W;
    localparam int FRAC_W = ppdmd_pkg::FRAC_W;
    localparam int PIX_W  = ppdmd_pkg::PIX_W;
    localparam int RAW_W  = ppdmd_pkg::RAW_W;
    localparam int DIV_N  = ppdmd_pkg::DIV_N;
    localparam int SQRT_N = ppdmd_pkg::SQRT_N;
    localparam int ROOT_W = ppdmd_pkg::ROOT_W;
    localparam int SREM_W = ppdmd_pkg::SREM_W;
    localparam int PEND_W = ppdmd_pkg::PEND_W;

    function automatic ppdmd_pkg::t_div div_step(input ppdmd_pkg::t_div s);
        logic [CNT_W:0]  t;
        logic [CNT_W:0]  diff;
        logic            ge;
        ppdmd_pkg::t_div o;
        begin
            o    = s;
            t    = {s.rem, s.work[SQ_W-1]};
            diff = t - {1'b0, s.divisor};
            ge   = (t >= {1'b0, s.divisor});
            o.rem  = ge ? diff[CNT_W-1:0] : t[CNT_W-1:0];
            o.work = {s.work[SQ_W-2:0], ge};
            return o;
        end
    endfunction

    function automatic ppdmd_pkg::t_sqr sqrt_step(input ppdmd_pkg::t_sqr s);
        logic [SREM_W+1:0] t;
        logic [SREM_W+1:0] trial;
        logic [SREM_W+1:0] diff;
        logic              ge;
        ppdmd_pkg::t_sqr   o;
        begin
            o     = s;
            t     = {s.rem, s.val[SQ_W-1:SQ_W-2]};
            trial = (SREM_W+2)'({s.root, 2'b01});
            diff  = t - trial;
            ge    = (t >= trial);
            o.rem  = ge ? diff[SREM_W-1:0] : t[SREM_W-1:0];
            o.root = {s.root[ROOT_W-2:0], ge};
            o.val  = {s.val[SQ_W-3:0], 2'b00};
            return o;
        end
    endfunction

    function automatic logic upd_hit(input ppdmd_pkg::t_ctl c, input logic [PIX_W-1:0] px);
        return c.valid && c.ok && (c.px == px) &&
               ((c.act == ppdmd_pkg::ACT_SUM) || (c.act == ppdmd_pkg::ACT_DEV));
    endfunction

    logic [RAW_W-1:0]  r_min;
    logic [RAW_W-1:0]  r_max;
    logic              r_clr_busy;
    logic [ADDR_W-1:0] r_clr_addr;
    logic [PEND_W-1:0] r_pend;
    logic [PEND_W-1:0] n_pend;

    ppdmd_pkg::t_s1  r_s1;
    ppdmd_pkg::t_s1  n_s1;
    ppdmd_pkg::t_upd r_s2;
    ppdmd_pkg::t_upd n_s2;
    ppdmd_pkg::t_upd r_s3;
    ppdmd_pkg::t_upd n_s3;
    ppdmd_pkg::t_div w_dv_first;
    ppdmd_pkg::t_div r_dv [DIV_N];
    ppdmd_pkg::t_div n_dv [DIV_N];
    ppdmd_pkg::t_sqr w_sq_first;
    ppdmd_pkg::t_sqr r_sq [SQRT_N];
    ppdmd_pkg::t_sqr n_sq [SQRT_N];

    logic                r_out_valid;
    logic [PIX_W-1:0]    r_out_px;
    logic [CNT_W-1:0]    r_out_cnt;
    logic [MEAN_W-1:0]   r_out_mean;
    logic [MEAN_W-1:0]   r_out_sd;

    ppdmd_pkg::t_action  w_act;
    logic                w_ok;
    logic                w_sv;
    logic                w_haz;
    logic                w_ready;
    logic                w_accept;
    logic                w_adv;
    logic                w_last_read;

    logic [ACC_W-1:0]    w_acc_q;
    logic [MEAN_W-1:0]   w_mean_q;
    logic [SQ_W-1:0]     w_sq_q;
    logic [CNT_W-1:0]    w_cnt;
    logic [SUM_W-1:0]    w_sum;
    logic [SUM_W:0]      w_sum_t;
    logic [SUM_W-1:0]    w_sum_sat;
    logic                w_full;
    logic [MEAN_W-1:0]   w_scaled;
    logic [MEAN_W-1:0]   w_dist;
    logic [PROD_W-1:0]   w_prod;
    logic [SQ_W:0]       w_sqs_t;
    logic [SQ_W-1:0]     w_sqs_new;

    logic                w_upd_we;
    logic                w_acc_we;
    logic                w_sqs_we;
    logic                w_mean_we;
    logic [MEAN_W-1:0]   w_mean_new;
    logic [ROOT_W-1:0]   w_root;
    logic [MEAN_W-1:0]   w_sd;

    logic                w_ram_acc_we;
    logic [ADDR_W-1:0]   w_ram_acc_waddr;
    logic [ACC_W-1:0]    w_ram_acc_wdata;
    logic                w_ram_sq_we;
    logic [SQ_W-1:0]     w_ram_sq_wdata;
    logic                w_ram_mean_we;
    logic [ADDR_W-1:0]   w_ram_mean_waddr;
    logic [MEAN_W-1:0]   w_ram_mean_wdata;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_min <= ppdmd_pkg::MIN_RAW_RESET;
            r_max <= ppdmd_pkg::MAX_RAW_RESET;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                ppdmd_pkg::CFG_MIN_RAW: r_min <= i_cfg_data[RAW_W-1:0];
                ppdmd_pkg::CFG_MAX_RAW: r_max <= i_cfg_data[RAW_W-1:0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clr_busy <= 1'b1;
            r_clr_addr <= '0;
        end else if (r_clr_busy) begin
            r_clr_addr <= r_clr_addr + ADDR_W'(1);
            if (r_clr_addr == ADDR_W'(ppdmd_pkg::PIXELS - 1)) begin
                r_clr_busy <= 1'b0;
            end
        end
    end

    // Input side and hazard check.
    assign w_act = ppdmd_pkg::t_action'(i_in.action);
    assign w_ok  = ({1'b0, i_in.pixel_index} < (PIX_W+1)'(ppdmd_pkg::PIXELS));
    assign w_sv  = (i_in.raw_depth > r_min) && (i_in.raw_depth < r_max);

    assign w_haz = upd_hit(r_s1.ctl, i_in.pixel_index) ||
                   upd_hit(r_s2.ctl, i_in.pixel_index) ||
                   upd_hit(r_s3.ctl, i_in.pixel_index) ||
                   (((w_act == ppdmd_pkg::ACT_DEV) || (w_act == ppdmd_pkg::ACT_READ)) &&
                    (r_pend != '0));

    assign w_last_read = r_sq[SQRT_N-1].ctl.valid &&
                         (r_sq[SQRT_N-1].ctl.act == ppdmd_pkg::ACT_READ);
    assign w_adv    = !w_last_read || !r_out_valid || o_out.ready;
    assign w_ready  = !r_clr_busy && w_adv && !w_haz;
    assign w_accept = i_in.valid && w_ready;
    assign i_in.ready = w_ready;

    always_comb begin
        n_s1.ctl.valid = w_accept;
        n_s1.ctl.act   = w_act;
        n_s1.ctl.px    = i_in.pixel_index;
        n_s1.ctl.ok    = w_ok;
        n_s1.ctl.sv    = w_sv;
        n_s1.raw       = i_in.raw_depth;
    end

    // Stage one: stored entries are available.
    assign w_cnt     = w_acc_q[ACC_W-1:SUM_W];
    assign w_sum     = w_acc_q[SUM_W-1:0];
    assign w_sum_t   = {1'b0, w_sum} + (SUM_W+1)'(r_s1.raw);
    assign w_sum_sat = w_sum_t[SUM_W] ? '1 : w_sum_t[SUM_W-1:0];
    assign w_full    = (w_cnt >= CNT_W'(ppdmd_pkg::MAX_FRAMES));
    assign w_scaled  = {r_s1.raw, FRAC_W'(0)};
    assign w_dist    = (w_scaled >= w_mean_q) ? (w_scaled - w_mean_q) : (w_mean_q - w_scaled);

    always_comb begin
        n_s2.ctl       = r_s1.ctl;
        n_s2.acc_we    = (r_s1.ctl.act == ppdmd_pkg::ACT_SUM) && r_s1.ctl.sv && !w_full;
        n_s2.acc_wdata = {w_cnt + CNT_W'(1), w_sum_sat};
        n_s2.sq_old    = w_sq_q;
        n_s2.term      = PROD_W'(w_dist);
        if (r_s1.ctl.act == ppdmd_pkg::ACT_MEAN) begin
            n_s2.dividend = SQ_W'({w_sum, FRAC_W'(0)});
            n_s2.divisor  = w_cnt;
            n_s2.zero     = (w_cnt == '0);
        end else begin
            n_s2.dividend = w_sq_q;
            n_s2.divisor  = w_cnt - CNT_W'(1);
            n_s2.zero     = (w_cnt < CNT_W'(2));
        end
        n_s2.cnt  = r_s1.ctl.ok ? w_cnt : '0;
        n_s2.mean = r_s1.ctl.ok ? w_mean_q : '0;
        if (!r_s1.ctl.ok) begin
            n_s2.zero = 1'b1;
        end
    end

    // Stage two: square of the distance.
    assign w_prod = r_s2.term[MEAN_W-1:0] * r_s2.term[MEAN_W-1:0];

    always_comb begin
        n_s3      = r_s2;
        n_s3.term = w_prod;
    end

    // Stage three: square sum update and store write back.
    assign w_sqs_t   = {1'b0, r_s3.sq_old} + (SQ_W+1)'(r_s3.term);
    assign w_sqs_new = w_sqs_t[SQ_W] ? '1 : w_sqs_t[SQ_W-1:0];
    assign w_upd_we  = w_adv && r_s3.ctl.valid && r_s3.ctl.ok;
    assign w_acc_we  = w_upd_we && r_s3.acc_we;
    assign w_sqs_we  = w_upd_we && (r_s3.ctl.act == ppdmd_pkg::ACT_DEV) && r_s3.ctl.sv;

    always_comb begin
        w_dv_first.ctl     = r_s3.ctl;
        w_dv_first.cnt     = r_s3.cnt;
        w_dv_first.mean    = r_s3.mean;
        w_dv_first.zero    = r_s3.zero;
        w_dv_first.divisor = r_s3.divisor;
        w_dv_first.rem     = '0;
        w_dv_first.work    = r_s3.dividend;
        n_dv[0] = div_step(w_dv_first);
        for (int k = 1; k < DIV_N; k++) begin
            n_dv[k] = div_step(r_dv[k-1]);
        end
    end

    assign w_mean_we  = w_adv && r_dv[DIV_N-1].ctl.valid && r_dv[DIV_N-1].ctl.ok &&
                        (r_dv[DIV_N-1].ctl.act == ppdmd_pkg::ACT_MEAN);
    assign w_mean_new = r_dv[DIV_N-1].zero ? '0 : r_dv[DIV_N-1].work[MEAN_W-1:0];

    always_comb begin
        w_sq_first.ctl  = r_dv[DIV_N-1].ctl;
        w_sq_first.cnt  = r_dv[DIV_N-1].cnt;
        w_sq_first.mean = r_dv[DIV_N-1].mean;
        w_sq_first.zero = r_dv[DIV_N-1].zero;
        w_sq_first.rem  = '0;
        w_sq_first.root = '0;
        w_sq_first.val  = r_dv[DIV_N-1].work;
        n_sq[0] = sqrt_step(w_sq_first);
        for (int k = 1; k < SQRT_N; k++) begin
            n_sq[k] = sqrt_step(r_sq[k-1]);
        end
    end

    assign w_root = r_sq[SQRT_N-1].root;
    assign w_sd   = r_sq[SQRT_N-1].zero ? '0 :
                    ((|w_root[ROOT_W-1:MEAN_W]) ? '1 : w_root[MEAN_W-1:0]);

    always_comb begin
        n_pend = r_pend;
        if (w_accept && (w_act == ppdmd_pkg::ACT_MEAN)) begin
            n_pend = n_pend + PEND_W'(1);
        end
        if (w_adv && r_dv[DIV_N-1].ctl.valid &&
            (r_dv[DIV_N-1].ctl.act == ppdmd_pkg::ACT_MEAN)) begin
            n_pend = n_pend - PEND_W'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pend         <= '0;
            r_s1.ctl.valid <= 1'b0;
            r_s2.ctl.valid <= 1'b0;
            r_s3.ctl.valid <= 1'b0;
            for (int k = 0; k < DIV_N; k++) begin
                r_dv[k].ctl.valid <= 1'b0;
            end
            for (int k = 0; k < SQRT_N; k++) begin
                r_sq[k].ctl.valid <= 1'b0;
            end
        end else begin
            r_pend <= n_pend;
            if (w_adv) begin
                r_s1 <= n_s1;
                r_s2 <= n_s2;
                r_s3 <= n_s3;
                r_dv <= n_dv;
                r_sq <= n_sq;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_adv && w_last_read) begin
            r_out_valid <= 1'b1;
        end else if (o_out.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_adv && w_last_read) begin
            r_out_px   <= r_sq[SQRT_N-1].ctl.px;
            r_out_cnt  <= r_sq[SQRT_N-1].cnt;
            r_out_mean <= r_sq[SQRT_N-1].mean;
            r_out_sd   <= w_sd;
        end
    end

    assign o_out.valid         = r_out_valid;
    assign o_out.result_pixel  = r_out_px;
    assign o_out.sample_count  = r_out_cnt;
    assign o_out.mean_depth    = r_out_mean;
    assign o_out.std_deviation = r_out_sd;

    // Stores; the clearing pass owns the write ports after reset.
    assign w_ram_acc_we     = r_clr_busy || w_acc_we;
    assign w_ram_acc_waddr  = r_clr_busy ? r_clr_addr : ADDR_W'(r_s3.ctl.px);
    assign w_ram_acc_wdata  = r_clr_busy ? '0 : r_s3.acc_wdata;
    assign w_ram_sq_we      = r_clr_busy || w_sqs_we;
    assign w_ram_sq_wdata   = r_clr_busy ? '0 : w_sqs_new;
    assign w_ram_mean_we    = r_clr_busy || w_mean_we;
    assign w_ram_mean_waddr = r_clr_busy ? r_clr_addr : ADDR_W'(r_dv[DIV_N-1].ctl.px);
    assign w_ram_mean_wdata = r_clr_busy ? '0 : w_mean_new;

    ppdmd_ram #(.WIDTH(ACC_W), .DEPTH(ppdmd_pkg::PIXELS)) u_acc_ram (
        .i_clk   (i_clk),
        .i_we    (w_ram_acc_we),
        .i_waddr (w_ram_acc_waddr),
        .i_wdata (w_ram_acc_wdata),
        .i_re    (w_adv),
        .i_raddr (ADDR_W'(i_in.pixel_index)),
        .o_rdata (w_acc_q)
    );

    ppdmd_ram #(.WIDTH(SQ_W), .DEPTH(ppdmd_pkg::PIXELS)) u_sq_ram (
        .i_clk   (i_clk),
        .i_we    (w_ram_sq_we),
        .i_waddr (w_ram_acc_waddr),
        .i_wdata (w_ram_sq_wdata),
        .i_re    (w_adv),
        .i_raddr (ADDR_W'(i_in.pixel_index)),
        .o_rdata (w_sq_q)
    );

    ppdmd_ram #(.WIDTH(MEAN_W), .DEPTH(ppdmd_pkg::PIXELS)) u_mean_ram (
        .i_clk   (i_clk),
        .i_we    (w_ram_mean_we),
        .i_waddr (w_ram_mean_waddr),
        .i_wdata (w_ram_mean_wdata),
        .i_re    (w_adv),
        .i_raddr (ADDR_W'(i_in.pixel_index)),
        .o_rdata (w_mean_q)
    );

`ifndef SYNTHESIS
    a_no_beat_while_clearing: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_clr_busy |-> !i_in.ready)
        else $error("input taken during the clearing pass");

    a_mean_tracked: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_dv[DIV_N-1].ctl.valid && (r_dv[DIV_N-1].ctl.act == ppdmd_pkg::ACT_MEAN))
        |-> (r_pend != '0))
        else $error("mean in divider not counted as pending");

    a_no_stale_read: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_accept && w_acc_we) |-> (i_in.pixel_index != r_s3.ctl.px))
        else $error("read of a pixel whose update is being written");

    a_result_from_pipe: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_out_valid) |-> $past(r_sq[SQRT_N-1].ctl.valid))
        else $error("result without a readout in the last stage");
`endif

endmodule

/* rtl/ppdmd_ram.sv */
// ----------------------------------------------------------------------------
// Generic RAM
// One write port and one read port with a registered, enabled read.
// ----------------------------------------------------------------------------
module ppdmd_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

/* tb/per_pixel_depth_mean_and_deviation_tb.sv */
// ----------------------------------------------------------------------------
// Per-pixel depth mean and deviation testbench
// Drives action beats into the depth statistics block while the sample and
// readout channels idle and stall at random. A per-pixel statistics predictor
// computes every readout, and a scoreboard checks each one field by field.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

import ppdmd_pkg::*;

typedef struct {
    logic [PIX_W-1:0]  px;
    logic [CNT_W-1:0]  cnt;
    logic [MEAN_W-1:0] mean;
    logic [MEAN_W-1:0] sd;
} t_pixel_stats;

class depth_stats_board;
    logic [RAW_W-1:0]  min_raw;
    logic [RAW_W-1:0]  max_raw;
    logic [CNT_W-1:0]  count_mem [PIXELS];
    logic [SUM_W-1:0]  sum_mem [PIXELS];
    logic [MEAN_W-1:0] mean_mem [PIXELS];
    logic [SQ_W-1:0]   square_mem [PIXELS];
    t_pixel_stats      pending_stats [$];
    int                errors;

    function new();
        min_raw = MIN_RAW_RESET;
        max_raw = MAX_RAW_RESET;
        errors  = 0;
        for (int i = 0; i < PIXELS; i++) begin
            count_mem[i]  = '0;
            sum_mem[i]    = '0;
            mean_mem[i]   = '0;
            square_mem[i] = '0;
        end
    endfunction

    function logic [63:0] floor_root(logic [63:0] v);
        logic [63:0] r;
        logic [63:0] b;
        r = 0;
        b = 64'h1 << 62;
        while (b > v) b >>= 2;
        while (b != 0) begin
            if (v >= r + b) begin
                v -= r + b;
                r = (r >> 1) + b;
            end else begin
                r >>= 1;
            end
            b >>= 2;
        end
        return r;
    endfunction

    function void note_beat(t_action act, logic [PIX_W-1:0] px, logic [RAW_W-1:0] raw);
        logic         in_range;
        logic [63:0]  s;
        logic [63:0]  a;
        logic [63:0]  m;
        logic [63:0]  d;
        t_pixel_stats e;
        in_range = (raw > min_raw) && (raw < max_raw);
        case (act)
            ACT_SUM: begin
                if (in_range && count_mem[px] < MAX_FRAMES) begin
                    s = 64'(sum_mem[px]) + 64'(raw);
                    count_mem[px] = count_mem[px] + CNT_W'(1);
                    sum_mem[px] = (s > 64'h3FF_FFFF) ? '1 : s[SUM_W-1:0];
                end
            end
            ACT_MEAN: begin
                if (count_mem[px] != 0) begin
                    s = (64'(sum_mem[px]) << 8) / 64'(count_mem[px]);
                    mean_mem[px] = s[MEAN_W-1:0];
                end else begin
                    mean_mem[px] = '0;
                end
            end
            ACT_DEV: begin
                if (in_range) begin
                    a = 64'(raw) << 8;
                    m = 64'(mean_mem[px]);
                    d = (a >= m) ? a - m : m - a;
                    s = 64'(square_mem[px]) + d * d;
                    square_mem[px] = (s > 64'h3FF_FFFF_FFFF_FFFF) ? '1 : s[SQ_W-1:0];
                end
            end
            default: begin
                e.px   = px;
                e.cnt  = count_mem[px];
                e.mean = mean_mem[px];
                e.sd   = '0;
                if (count_mem[px] >= 2) begin
                    s = floor_root(64'(square_mem[px]) / (64'(count_mem[px]) - 1));
                    e.sd = (s > 64'hFF_FFFF) ? '1 : s[MEAN_W-1:0];
                end
                pending_stats.insert(pending_stats.size(), e);
            end
        endcase
    endfunction

    function void check_beat(logic [PIX_W-1:0] px, logic [CNT_W-1:0] cnt,
                             logic [MEAN_W-1:0] mean, logic [MEAN_W-1:0] sd);
        t_pixel_stats e;
        if (pending_stats.size() == 0) begin
            $error("unexpected readout beat for pixel %0d", px);
            errors++;
            return;
        end
        e = pending_stats.pop_front();
        if (px !== e.px) begin
            $error("result_pixel: expected %0d, actual %0d", e.px, px);
            errors++;
        end
        if (cnt !== e.cnt) begin
            $error("sample_count: expected %0d, actual %0d", e.cnt, cnt);
            errors++;
        end
        if (mean !== e.mean) begin
            $error("mean_depth: expected %0d, actual %0d", e.mean, mean);
            errors++;
        end
        if (sd !== e.sd) begin
            $error("std_deviation: expected %0d, actual %0d", e.sd, sd);
            errors++;
        end
    endfunction
endclass

module per_pixel_depth_mean_and_deviation_tb;
    logic                 i_clk;
    logic                 i_rst_n;
    logic                 i_cfg_we;
    logic [CFG_IDX_W-1:0] i_cfg_index;
    logic [CFG_W-1:0]     i_cfg_data;

    ppdmd_in_if  in_ch();
    ppdmd_out_if out_ch();

    per_pixel_depth_mean_and_deviation uut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .i_in        (in_ch),
        .o_out       (out_ch)
    );

    depth_stats_board board = new();
    int send_idle = 0;
    int recv_idle = 0;
    int hold_left = 0;
    logic [PIX_W-1:0] pixel_pool [8];

    always begin
        i_clk = 1'b1;
        #5;
        i_clk = 1'b0;
        #5;
    end

    initial begin
        i_rst_n            = 1'b0;
        i_cfg_we           = 1'b0;
        i_cfg_index        = CFG_MIN_RAW;
        i_cfg_data         = '0;
        in_ch.valid        = 1'b0;
        in_ch.action       = ACT_SUM;
        in_ch.pixel_index  = '0;
        in_ch.raw_depth    = '0;
        out_ch.ready       = 1'b0;
    end

    always @(posedge i_clk) begin
        if (out_ch.valid && out_ch.ready)
            board.check_beat(out_ch.result_pixel, out_ch.sample_count,
                             out_ch.mean_depth, out_ch.std_deviation);
        if (hold_left > 0) begin
            hold_left--;
            out_ch.ready <= 1'b0;
        end else begin
            out_ch.ready <= ($urandom_range(99) >= recv_idle);
        end
    end

    task automatic send_beat(t_action act, logic [PIX_W-1:0] px, logic [RAW_W-1:0] raw);
        while ($urandom_range(99) < send_idle) begin
            in_ch.valid <= 1'b0;
            @(posedge i_clk);
        end
        in_ch.valid       <= 1'b1;
        in_ch.action      <= act;
        in_ch.pixel_index <= px;
        in_ch.raw_depth   <= raw;
        do @(posedge i_clk); while (!in_ch.ready);
        board.note_beat(act, px, raw);
    endtask

    task automatic drain();
        in_ch.valid <= 1'b0;
        @(posedge i_clk);
        while (board.pending_stats.size() != 0) @(posedge i_clk);
        repeat (120) @(posedge i_clk);
    endtask

    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_W-1:0] data);
        i_cfg_we    <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= data;
        @(posedge i_clk);
        if (idx == CFG_MIN_RAW)
            board.min_raw = data;
        else
            board.max_raw = data;
    endtask

    task automatic set_range(logic [RAW_W-1:0] lo, logic [RAW_W-1:0] hi);
        write_reg(CFG_MIN_RAW, lo);
        write_reg(CFG_MAX_RAW, hi);
        i_cfg_we <= 1'b0;
    endtask

    task automatic pixel_run(logic [PIX_W-1:0] px);
        int n;
        n = $urandom_range(8, 1);
        for (int i = 0; i < n; i++)
            send_beat(ACT_SUM, px, RAW_W'($urandom_range(board.max_raw, board.min_raw)));
        send_beat(ACT_MEAN, px, RAW_W'($urandom));
        for (int i = 0; i < n; i++)
            send_beat(ACT_DEV, px, RAW_W'($urandom_range(board.max_raw, board.min_raw)));
        send_beat(ACT_READ, px, RAW_W'($urandom));
    endtask

    task automatic random_phase(int items, bit pressure);
        int sent;
        logic [PIX_W-1:0] px;
        sent = 0;
        for (int i = 0; i < 8; i++) pixel_pool[i] = PIX_W'($urandom_range(4095));
        pixel_pool[0] = '0;
        pixel_pool[1] = '1;
        while (sent < items) begin
            px = ($urandom_range(3) == 0) ? PIX_W'($urandom_range(4095))
                                          : pixel_pool[$urandom_range(7)];
            if (pressure && sent >= items / 3 && sent < items / 3 + 20) begin
                hold_left = 400;
                sent += 20;
            end
            if (pressure && sent >= 2 * items / 3 && sent < 2 * items / 3 + 20) begin
                drain();
                sent += 20;
            end
            if ($urandom_range(4) != 0) begin
                pixel_run(px);
                sent += 10;
            end else begin
                send_beat(t_action'($urandom_range(3)), px, RAW_W'($urandom));
                sent++;
            end
        end
        drain();
    endtask

    initial begin
        #30ms;
        $display("per_pixel_depth_mean_and_deviation_tb: errors");
        $finish;
    end

    initial begin
        logic [RAW_W-1:0] lo;
        logic [RAW_W-1:0] hi;
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        send_beat(ACT_READ, 12'd0, 16'hFFFF);
        send_beat(ACT_SUM, 12'hFFF, 16'd3201);
        send_beat(ACT_SUM, 12'hFFF, 16'd63999);
        send_beat(ACT_SUM, 12'hFFF, 16'd3200);
        send_beat(ACT_SUM, 12'hFFF, 16'd64000);
        send_beat(ACT_SUM, 12'hFFF, 16'd0);
        send_beat(ACT_SUM, 12'hFFF, 16'hFFFF);
        send_beat(ACT_READ, 12'hFFF, 16'd0);
        send_beat(ACT_MEAN, 12'hFFF, 16'd0);
        send_beat(ACT_DEV, 12'hFFF, 16'd3201);
        send_beat(ACT_DEV, 12'hFFF, 16'd63999);
        send_beat(ACT_DEV, 12'hFFF, 16'hFFFF);
        send_beat(ACT_READ, 12'hFFF, 16'hFFFF);
        send_beat(ACT_SUM, 12'd7, 16'd5000);
        send_beat(ACT_MEAN, 12'd7, 16'd0);
        send_beat(ACT_DEV, 12'd7, 16'd5001);
        send_beat(ACT_READ, 12'd7, 16'd0);
        send_beat(ACT_MEAN, 12'd8, 16'd0);
        send_beat(ACT_READ, 12'd8, 16'd0);
        drain();

        set_range(16'd0, 16'hFFFF);
        send_beat(ACT_SUM, 12'd9, 16'hFFFE);
        send_beat(ACT_SUM, 12'd9, 16'd1);
        send_beat(ACT_DEV, 12'd9, 16'hFFFE);
        send_beat(ACT_DEV, 12'd9, 16'hFFFE);
        send_beat(ACT_READ, 12'd9, 16'd0);
        drain();

        set_range(16'hFFFF, 16'd0);
        send_beat(ACT_SUM, 12'd10, 16'h8000);
        send_beat(ACT_DEV, 12'd10, 16'h7FFF);
        send_beat(ACT_READ, 12'd10, 16'd0);
        drain();

        set_range(16'd0, 16'hFFFF);
        for (int i = 0; i < 1030; i++)
            send_beat(ACT_SUM, 12'd100, RAW_W'($urandom));
        send_beat(ACT_MEAN, 12'd100, 16'd0);
        send_beat(ACT_READ, 12'd100, 16'd0);
        drain();

        send_idle = 33;
        recv_idle = 63;
        set_range(MIN_RAW_RESET, MAX_RAW_RESET);
        random_phase(100, 1'b1);

        send_idle = 63;
        recv_idle = 33;
        set_range(16'd0, 16'hFFFF);
        random_phase(100, 1'b0);

        send_idle = 0;
        recv_idle = 0;
        lo = RAW_W'($urandom);
        hi = RAW_W'($urandom);
        if (lo > hi) set_range(hi, lo);
        else set_range(lo, hi);
        random_phase(100, 1'b1);

        if (board.errors == 0)
            $display("per_pixel_depth_mean_and_deviation_tb: clean");
        else
            $display("per_pixel_depth_mean_and_deviation_tb: errors");
        $finish;
    end
endmodule

/* filelist.f */
rtl/ppdmd_pkg.sv
rtl/ppdmd_in_if.sv
rtl/ppdmd_out_if.sv
rtl/ppdmd_ram.sv
rtl/per_pixel_depth_mean_and_deviation.sv
tb/per_pixel_depth_mean_and_deviation_tb.sv
